/* hw/rtl/swle_pkg.sv */
// ----------------------------------------------------------------------------
// swle_pkg
// Types and constants shared by the single-wire RGB LED encoder files.
// ----------------------------------------------------------------------------
package swle_pkg;

  localparam int unsigned LED_POS_W  = 10;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned BIT_IDX_W  = 5;
  localparam int unsigned COLOUR_W   = 24;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 5'd23;

  localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [2:0] REG_ONE_LOW   = 3'd3;
  localparam logic [2:0] REG_LATCH_LOW = 3'd4;

  typedef struct packed {
    logic       command;
    logic [9:0] led_position;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } in_word_t;

  typedef struct packed {
    logic data_line;
    logic busy_res;
    logic frame_done;
    logic request_rejected;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  zero_high_ticks;
    logic [7:0]  zero_low_ticks;
    logic [7:0]  one_high_ticks;
    logic [7:0]  one_low_ticks;
    logic [15:0] latch_low_ticks;
  } cfg_t;

endpackage

/* hw/rtl/swle_cfg_regs.sv */
// ----------------------------------------------------------------------------
// swle_cfg_regs
// APB-style register file for the bit and reset period timings.
// ----------------------------------------------------------------------------
module swle_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [swle_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [swle_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [swle_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output swle_pkg::cfg_t                      cfg
);

  swle_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_high_ticks <= 8'd4;
      cfg_r.zero_low_ticks  <= 8'd10;
      cfg_r.one_high_ticks  <= 8'd10;
      cfg_r.one_low_ticks   <= 8'd5;
      cfg_r.latch_low_ticks <= 16'd3000;
    end else if (wr_en) begin
      case (reg_idx)
        swle_pkg::REG_ZERO_HIGH: cfg_r.zero_high_ticks <= cfg_pwdata[7:0];
        swle_pkg::REG_ZERO_LOW:  cfg_r.zero_low_ticks  <= cfg_pwdata[7:0];
        swle_pkg::REG_ONE_HIGH:  cfg_r.one_high_ticks  <= cfg_pwdata[7:0];
        swle_pkg::REG_ONE_LOW:   cfg_r.one_low_ticks   <= cfg_pwdata[7:0];
        swle_pkg::REG_LATCH_LOW: cfg_r.latch_low_ticks <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swle_pkg::REG_ZERO_HIGH: cfg_prdata = {24'd0, cfg_r.zero_high_ticks};
      swle_pkg::REG_ZERO_LOW:  cfg_prdata = {24'd0, cfg_r.zero_low_ticks};
      swle_pkg::REG_ONE_HIGH:  cfg_prdata = {24'd0, cfg_r.one_high_ticks};
      swle_pkg::REG_ONE_LOW:   cfg_prdata = {24'd0, cfg_r.one_low_ticks};
      swle_pkg::REG_LATCH_LOW: cfg_prdata = {16'd0, cfg_r.latch_low_ticks};
      default:                 cfg_prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/swle_frame_core.sv */
// ----------------------------------------------------------------------------
// swle_frame_core
// Frame sequencer: one tick per word, state update and registered result.
// ----------------------------------------------------------------------------
module swle_frame_core #(
  parameter int unsigned MAX_LEDS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swle_pkg::cfg_t      cfg,
  input  logic                tick_valid,
  input  swle_pkg::in_word_t  tick_word,
  output logic                tick_stall,
  output logic                out_valid,
  output swle_pkg::out_word_t out_word,
  input  logic                out_stall
);

  localparam int unsigned POS_LIMIT = (MAX_LEDS > 1024) ? 1023 : MAX_LEDS - 1;

  typedef enum logic [1:0] {PH_IDLE, PH_OPEN, PH_BITS, PH_CLOSE} phase_t;

  function automatic logic [swle_pkg::TICK_W-1:0] at_least_one(
    input logic [swle_pkg::TICK_W-1:0] v
  );
    at_least_one = (v == '0) ? swle_pkg::TICK_W'(1) : v;
  endfunction

  phase_t                              phase_r, phase_nxt, ph_e;
  logic [swle_pkg::TICK_W-1:0]         tick_r, tick_nxt, tick_e, tick_inc, dur;
  logic [swle_pkg::BIT_IDX_W-1:0]      bit_r, bit_nxt, bit_e, bit_sel;
  logic [swle_pkg::LED_POS_W-1:0]      led_r, led_nxt, led_e;
  logic [swle_pkg::LED_POS_W-1:0]      target_r, target_nxt, target_e, pos;
  logic [swle_pkg::COLOUR_W-1:0]       colour_r, colour_nxt, colour_e, word;
  logic                                high_r, high_nxt, high_e;
  logic                                cur_bit;
  logic                                take, advance;
  logic                                out_valid_r;
  swle_pkg::out_word_t                 out_word_r, res;

  assign take       = !out_valid_r || !out_stall;
  assign advance    = tick_valid && take;
  assign tick_stall = !take;
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;

  always_comb begin
    ph_e     = phase_r;
    tick_e   = tick_r;
    bit_e    = bit_r;
    led_e    = led_r;
    target_e = target_r;
    colour_e = colour_r;
    high_e   = high_r;
    res      = '0;
    pos      = tick_word.led_position;
    if (pos > swle_pkg::LED_POS_W'(POS_LIMIT)) begin
      pos = swle_pkg::LED_POS_W'(POS_LIMIT);
    end
    if (tick_word.command) begin
      if (phase_r != PH_IDLE) begin
        res.request_rejected = 1'b1;
      end else begin
        ph_e     = PH_OPEN;
        tick_e   = '0;
        bit_e    = '0;
        led_e    = '0;
        high_e   = 1'b0;
        target_e = pos;
        colour_e = {tick_word.green_level, tick_word.red_level, tick_word.blue_level};
      end
    end

    word     = (led_e == target_e) ? colour_e : '0;
    bit_sel  = swle_pkg::LAST_BIT - bit_e;
    cur_bit  = word[bit_sel];
    tick_inc = tick_e + swle_pkg::TICK_W'(1);

    phase_nxt  = ph_e;
    tick_nxt   = tick_e;
    bit_nxt    = bit_e;
    led_nxt    = led_e;
    target_nxt = target_e;
    colour_nxt = colour_e;
    high_nxt   = high_e;
    dur        = '0;

    case (ph_e)
      PH_OPEN, PH_CLOSE: begin
        res.busy_res = 1'b1;
        tick_nxt     = tick_inc;
        if (tick_inc >= at_least_one(cfg.latch_low_ticks)) begin
          tick_nxt = '0;
          if (ph_e == PH_OPEN) begin
            phase_nxt = PH_BITS;
            high_nxt  = 1'b1;
            bit_nxt   = '0;
            led_nxt   = '0;
          end else begin
            res.frame_done = 1'b1;
            phase_nxt      = PH_IDLE;
          end
        end
      end
      PH_BITS: begin
        res.busy_res  = 1'b1;
        res.data_line = high_e;
        if (high_e) begin
          dur = {8'd0, cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks};
        end else begin
          dur = {8'd0, cur_bit ? cfg.one_low_ticks : cfg.zero_low_ticks};
        end
        tick_nxt = tick_inc;
        if (tick_inc >= at_least_one(dur)) begin
          tick_nxt = '0;
          if (high_e) begin
            high_nxt = 1'b0;
          end else begin
            high_nxt = 1'b1;
            if (bit_e == swle_pkg::LAST_BIT) begin
              bit_nxt = '0;
              if (led_e >= target_e) begin
                phase_nxt = PH_CLOSE;
                high_nxt  = 1'b0;
              end else begin
                led_nxt = led_e + swle_pkg::LED_POS_W'(1);
              end
            end else begin
              bit_nxt = bit_e + swle_pkg::BIT_IDX_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      led_r       <= '0;
      target_r    <= '0;
      colour_r    <= '0;
      high_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= tick_valid;
      end
      if (advance) begin
        phase_r    <= phase_nxt;
        tick_r     <= tick_nxt;
        bit_r      <= bit_nxt;
        led_r      <= led_nxt;
        target_r   <= target_nxt;
        colour_r   <= colour_nxt;
        high_r     <= high_nxt;
        out_word_r <= res;
      end
    end
  end

endmodule

/* hw/rtl/single_wire_rgb_led_encoder_unit.sv */
// ----------------------------------------------------------------------------
// single_wire_rgb_led_encoder_unit
// Single-wire RGB LED chain encoder: one input word per line tick.
// ----------------------------------------------------------------------------
//  channel | ports                          | word
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_stall, in_word    | tick or start request
//  result  | out_valid, out_stall, out_word | line level and frame status
//  config  | cfg_psel .. cfg_pready (APB)   | timing registers, 4-byte stride
//
//  One word per clock unless out_stall holds; a word passes the input
//  register, then the result register in the frame sequencer, to out_word.
//  Synchronous active-low reset; no clearing pass, ready right after reset.
//  out_stall holds a full result; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module single_wire_rgb_led_encoder_unit #(
  parameter int unsigned MAX_LEDS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  swle_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output swle_pkg::out_word_t              out_word,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [swle_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [swle_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [swle_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  swle_pkg::cfg_t     cfg;
  swle_pkg::in_word_t in_word_r;
  logic               in_valid_r;
  logic               core_stall;

  assign in_stall = in_valid_r && core_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
      if (in_valid) begin
        in_word_r <= in_word;
      end
    end
  end

  swle_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  swle_frame_core #(
    .MAX_LEDS (MAX_LEDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .tick_valid (in_valid_r),
    .tick_word  (in_word_r),
    .tick_stall (core_stall),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .out_stall  (out_stall)
  );

endmodule
